>>> hdl/rqr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue package
// Shared sizes, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rqr_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 7;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int STAMP_W = 64;
  localparam int ENTRY_W = VAL_W + STAMP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_POP_AT = 2'd2;
  localparam logic [1:0] ACT_DELETE = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       push;
    logic       idx_zero;
    logic       idx_pos;
    logic       idx_inc;
    logic       capture;
    logic       shift_wr;
    logic       occ_dec;
    logic       set_status;
    logic [1:0] status_code;
    logic       load_out;
  } rqr_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       empty;
    logic       pos_miss;
    logic       match;
    logic       last;
    logic       shift_end;
  } rqr_stat_t;

endpackage
`default_nettype wire

>>> hdl/rqr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/rqr_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue datapath
// Holds the request, the capacity register, the entry count, the entry
// memory and the result register, and acts on the controller's commands.
// ----------------------------------------------------------------------------
module rqr_dpath
  import rqr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          in_action,
  input  wire logic [VAL_W-1:0]    in_item_value,
  input  wire logic [STAMP_W-1:0]  in_arrival_stamp,
  input  wire logic [POS_W-1:0]    in_position,
  input  wire logic                cfg_we,
  input  wire logic [CAP_W-1:0]    cfg_data,
  input  wire rqr_cmd_t            cmd,
  output rqr_stat_t                stat,
  output logic [1:0]               out_status,
  output logic [VAL_W-1:0]         out_removed_value,
  output logic [STAMP_W-1:0]       out_removed_stamp,
  output logic [CAP_W-1:0]         out_entry_count
);

  logic [1:0]         act_r;
  logic [VAL_W-1:0]   key_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [POS_W-1:0]   pos_r;
  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   idx_m1;
  logic [VAL_W-1:0]   rem_val_r;
  logic [STAMP_W-1:0] rem_stamp_r;
  logic [1:0]         status_r;
  logic [CMP_W-1:0]   lim_eff;
  logic [CMP_W-1:0]   occ_cmp;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  rqr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_nxt[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign occ_cmp = CMP_W'(occ_r);
  assign lim_eff = (CMP_W'(cap_r) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(cap_r);
  assign idx_m1  = idx_r - CNT_W'(1);

  always_comb begin
    stat.action    = act_r;
    stat.full      = (occ_cmp >= lim_eff) || (occ_cmp >= DEPTH_CMP);
    stat.empty     = (occ_r == '0);
    stat.pos_miss  = (CMP_W'(pos_r) >= occ_cmp);
    stat.match     = (ram_rdata[ENTRY_W-1:STAMP_W] == key_r);
    stat.last      = ((idx_r + CNT_W'(1)) >= occ_r);
    stat.shift_end = (idx_r >= occ_r);
  end

  always_comb begin
    priority if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_pos) begin
      idx_nxt = CNT_W'(pos_r);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_comb begin
    priority if (cmd.push) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (cmd.occ_dec) begin
      occ_nxt = occ_r - CNT_W'(1);
    end else begin
      occ_nxt = occ_r;
    end
  end

  always_comb begin
    ram_we = cmd.push || cmd.shift_wr;
    if (cmd.push) begin
      ram_waddr = occ_r[ADDR_W-1:0];
      ram_wdata = {key_r, stamp_r};
    end else begin
      ram_waddr = idx_m1[ADDR_W-1:0];
      ram_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      occ_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch) begin
      act_r   <= in_action;
      key_r   <= in_item_value;
      stamp_r <= in_arrival_stamp;
      pos_r   <= in_position;
    end
    if (cmd.latch) begin
      rem_val_r   <= '0;
      rem_stamp_r <= '0;
    end else if (cmd.capture) begin
      rem_val_r   <= ram_rdata[ENTRY_W-1:STAMP_W];
      rem_stamp_r <= ram_rdata[STAMP_W-1:0];
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.load_out) begin
      out_status        <= status_r;
      out_removed_value <= rem_val_r;
      out_removed_stamp <= rem_stamp_r;
      out_entry_count   <= CAP_W'(occ_r);
    end
  end

endmodule
`default_nettype wire

>>> hdl/rqr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue controller
// Sequences one request at a time: decode, entry read, linear search,
// gap-closing shift and result hand-off.
// ----------------------------------------------------------------------------
module rqr_ctrl
  import rqr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire rqr_stat_t stat,
  output rqr_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_TAKE   = 3'd2;
  localparam logic [2:0] S_SRCH   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.action)
          ACT_PUSH: begin
            cmd.set_status = 1'b1;
            if (stat.full) begin
              cmd.status_code = ST_FULL;
            end else begin
              cmd.push        = 1'b1;
              cmd.status_code = ST_DONE;
            end
            state_nxt = S_RESP;
          end
          ACT_POP: begin
            if (stat.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_MISS;
              state_nxt       = S_RESP;
            end else begin
              cmd.idx_zero = 1'b1;
              state_nxt    = S_TAKE;
            end
          end
          ACT_POP_AT: begin
            if (stat.pos_miss) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_MISS;
              state_nxt       = S_RESP;
            end else begin
              cmd.idx_pos = 1'b1;
              state_nxt   = S_TAKE;
            end
          end
          ACT_DELETE: begin
            if (stat.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_MISS;
              state_nxt       = S_RESP;
            end else begin
              cmd.idx_zero = 1'b1;
              state_nxt    = S_SRCH;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_TAKE: begin
        cmd.capture = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_SHIFT;
      end
      S_SRCH: begin
        priority if (stat.match) begin
          cmd.capture = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SHIFT;
        end else if (stat.last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_MISS;
          state_nxt       = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          cmd.occ_dec     = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_DONE;
          state_nxt       = S_RESP;
        end else begin
          cmd.shift_wr = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/request_queue_with_removal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue with removal
// Bounded first-in first-out queue of requests with pop at any position and
// delete by value.
//
// A request enters on the in_ channel (valid/ready) and carries an action,
// a value, an arrival stamp and a position. Each request gives exactly one
// result on the out_ channel: a status, the removed value and stamp, and the
// entry count afterwards. cfg_we writes the capacity limit; the user must
// do so only while idle, as the block itself does not enforce it. The
// block works on one request at a time; in_ready is high only between
// requests. A push, or a pop that finds nothing, goes from decode straight
// to its result. Pop head or pop at position k moves the entries behind the
// removed one forward through the single entry memory at one per cycle.
// Delete by value searches that memory at one entry per cycle and on a hit
// then closes the gap the same way; a miss gives its result once the last
// entry has been searched. Reset empties the queue and sets the limit to
// 64; the entry memory needs no clearing. A result waits in the output
// register while the receiver stalls; the next request is still accepted
// and processed, and only its own result waits for the register to free up.
// ----------------------------------------------------------------------------
module request_queue_with_removal
  import rqr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic [VAL_W-1:0]   in_item_value,
  input  wire logic [STAMP_W-1:0] in_arrival_stamp,
  input  wire logic [POS_W-1:0]   in_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic [VAL_W-1:0]        out_removed_value,
  output logic [STAMP_W-1:0]      out_removed_stamp,
  output logic [CAP_W-1:0]        out_entry_count,
  input  wire logic               cfg_we,
  input  wire logic [CAP_W-1:0]   cfg_data
);

  rqr_cmd_t  cmd;
  rqr_stat_t stat;

  rqr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rqr_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_item_value    (in_item_value),
    .in_arrival_stamp (in_arrival_stamp),
    .in_position      (in_position),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_removed_stamp(out_removed_stamp),
    .out_entry_count  (out_entry_count)
  );

endmodule
`default_nettype wire

>>> hdl/rqr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue checker
// Port-level checks on the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module rqr_checker
  import rqr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_status,
  input wire logic [VAL_W-1:0]   out_removed_value,
  input wire logic [STAMP_W-1:0] out_removed_stamp,
  input wire logic [CAP_W-1:0]   out_entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_removed_value) && $stable(out_removed_stamp)
      && $stable(out_entry_count))
    else $error("Stalled result changed or dropped.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Reset did not clear the channels.");

  a_nothing_removed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |->
      out_removed_value == '0 && out_removed_stamp == '0)
    else $error("Failed request reported a removed entry.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CAP_W'(DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request accepted while another was in progress.");

endmodule

bind request_queue_with_removal rqr_checker u_rqr_checker (.*);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Request queue with removal testbench
// Drives push, pop head, pop at position and delete by value requests into
// the queue and keeps its own image of the queue contents to predict every
// result. A short directed sequence covers the empty, full and not-found
// cases, the limit extremes and a limit lowered below the held count. Random
// phases under several capacity limits follow. Both channels idle in random
// bursts until the last phase.
// ----------------------------------------------------------------------------
module tb;
  import rqr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int NUM_PHASES     = 6;

  typedef struct packed {
    logic [1:0]         action;
    logic [VAL_W-1:0]   value;
    logic [STAMP_W-1:0] stamp;
    logic [POS_W-1:0]   position;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VAL_W-1:0]   value;
    logic [STAMP_W-1:0] stamp;
    logic [CAP_W-1:0]   count;
  } outcome_t;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic     is_cfg;
    logic     typed;
    request_t req;
    outcome_t want;
  } step_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_action;
  logic [VAL_W-1:0]   in_item_value;
  logic [STAMP_W-1:0] in_arrival_stamp;
  logic [POS_W-1:0]   in_position;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [VAL_W-1:0]   out_removed_value;
  logic [STAMP_W-1:0] out_removed_stamp;
  logic [CAP_W-1:0]   out_entry_count;
  logic               cfg_we;
  logic [CAP_W-1:0]   cfg_data;

  entry_t           queue_image[$];
  logic [CAP_W-1:0] limit_reg;
  outcome_t         expected_results[$];
  step_t            directed_rows[$];
  int unsigned      mismatches = 0;
  int unsigned      idle_cycles;
  int unsigned      calm_left = 0;
  bit               quiet_tail = 1'b0;

  request_queue_with_removal dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_item_value    (in_item_value),
    .in_arrival_stamp (in_arrival_stamp),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_removed_stamp(out_removed_stamp),
    .out_entry_count  (out_entry_count),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic outcome_t apply_request(input request_t r);
    outcome_t    res;
    int unsigned lim;
    int          hit;
    res = '0;
    res.status = ST_MISS;
    lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
    hit = -1;
    case (r.action)
      ACT_PUSH: begin
        if (queue_image.size() >= lim) begin
          res.status = ST_FULL;
        end else begin
          queue_image.push_back('{value: r.value, stamp: r.stamp});
          res.status = ST_DONE;
        end
      end
      ACT_POP: if (queue_image.size() != 0) hit = 0;
      ACT_POP_AT: if (r.position < queue_image.size()) hit = r.position;
      default: begin
        for (int i = 0; i < queue_image.size(); i++) begin
          if (hit < 0 && queue_image[i].value == r.value) hit = i;
        end
      end
    endcase
    if (hit >= 0) begin
      res.status = ST_DONE;
      res.value = queue_image[hit].value;
      res.stamp = queue_image[hit].stamp;
      queue_image.delete(hit);
    end
    res.count = CAP_W'(queue_image.size());
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return VAL_W'($urandom_range(0, 3));
      1: return {1'b1, {(VAL_W-1){1'b0}}};
      2: return {1'b0, {(VAL_W-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] random_stamp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic request_t make_request(input int unsigned push_pct);
    request_t    r;
    int unsigned n;
    n = queue_image.size();
    r.value = random_value();
    r.stamp = random_stamp();
    r.position = POS_W'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < push_pct) begin
      r.action = ACT_PUSH;
    end else begin
      case ($urandom_range(0, 2))
        0: r.action = ACT_POP;
        1: r.action = ACT_POP_AT;
        default: r.action = ACT_DELETE;
      endcase
      if (n != 0 && $urandom_range(0, 4) != 0) begin
        if (r.action == ACT_POP_AT) r.position = POS_W'($urandom_range(0, n - 1));
        if (r.action == ACT_DELETE) r.value = queue_image[$urandom_range(0, n - 1)].value;
      end
    end
    return r;
  endfunction

  task automatic add_row(input logic typed, input logic [1:0] action,
                         input logic [VAL_W-1:0] value, input logic [STAMP_W-1:0] stamp,
                         input logic [POS_W-1:0] position, input logic [1:0] status,
                         input logic [VAL_W-1:0] rval, input logic [STAMP_W-1:0] rstamp,
                         input logic [CAP_W-1:0] count);
    step_t s;
    s.is_cfg = 1'b0;
    s.typed = typed;
    s.req = '{action: action, value: value, stamp: stamp, position: position};
    s.want = '{status: status, value: rval, stamp: rstamp, count: count};
    directed_rows.push_back(s);
  endtask

  task automatic add_cfg(input logic [CAP_W-1:0] cap);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.req.value = VAL_W'(cap);
    directed_rows.push_back(s);
  endtask

  task automatic write_limit(input logic [CAP_W-1:0] cap);
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = cap;
  endtask

  // The request is held until accepted; afterwards the line either drops
  // for a random pause, drops because the phase ends, or stays high.
  task automatic issue(input request_t r, input logic typed, input outcome_t want,
                       input logic closing);
    outcome_t predicted;
    in_valid <= 1'b1;
    in_action <= r.action;
    in_item_value <= r.value;
    in_arrival_stamp <= r.stamp;
    in_position <= r.position;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(r);
    expected_results.push_back(typed ? want : predicted);
    if (closing) begin
      in_valid <= 1'b0;
    end else if (calm_left != 0) begin
      calm_left--;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(20, 60);
    end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string what, input logic [STAMP_W-1:0] want,
                             input logic [STAMP_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %h %h %h %h",
                 $time, out_status, out_removed_value, out_removed_stamp, out_entry_count);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", STAMP_W'(want.status), STAMP_W'(out_status));
        check_field("removed_value", STAMP_W'(want.value), STAMP_W'(out_removed_value));
        check_field("removed_stamp", want.stamp, out_removed_stamp);
        check_field("entry_count", STAMP_W'(want.count), STAMP_W'(out_entry_count));
      end
    end
  end

  initial begin : result_stall
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned cap_plan[NUM_PHASES];
    int unsigned len_plan[NUM_PHASES];
    int unsigned push_plan[NUM_PHASES];
    request_t    r;
    logic        closing;
    cap_plan = '{64, 1, 127, 2, 0, 64};
    len_plan = '{260, 140, 200, 160, 100, 240};
    push_plan = '{75, 40, 75, 55, 30, 55};
    cap_plan[3] = $urandom_range(2, 63);
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_PUSH;
    in_item_value <= '0;
    in_arrival_stamp <= '0;
    in_position <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    limit_reg = CAP_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(1, ACT_POP, 0, 0, 0, ST_MISS, 0, 0, 0);
    add_row(1, ACT_POP_AT, 0, 0, 0, ST_MISS, 0, 0, 0);
    add_row(1, ACT_DELETE, 0, 0, 0, ST_MISS, 0, 0, 0);
    add_row(1, ACT_PUSH, 32'h7FFF_FFFF, '1, 63, ST_DONE, 0, 0, 1);
    add_row(1, ACT_PUSH, 32'h8000_0000, 0, 0, ST_DONE, 0, 0, 2);
    add_row(0, ACT_PUSH, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0);
    add_row(1, ACT_POP_AT, 0, 0, 63, ST_MISS, 0, 0, 3);
    add_row(0, ACT_POP_AT, 0, 0, 1, 0, 0, 0, 0);
    add_row(1, ACT_DELETE, 5, 0, 0, ST_MISS, 0, 0, 2);
    add_row(0, ACT_DELETE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(1, ACT_POP, 0, 0, 0, ST_DONE, 32'h7FFF_FFFF, '1, 0);
    add_cfg(1);
    add_row(0, ACT_PUSH, 32'h1234_5678, 64'hA5A5_A5A5_5A5A_5A5A, 0, 0, 0, 0, 0);
    add_row(1, ACT_PUSH, 1, 2, 0, ST_FULL, 0, 0, 1);
    add_cfg(0);
    add_row(1, ACT_PUSH, 3, 4, 0, ST_FULL, 0, 0, 1);
    add_row(0, ACT_POP_AT, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, ACT_PUSH, 5, 6, 0, ST_FULL, 0, 0, 0);
    add_cfg(127);
    add_row(0, ACT_PUSH, 0, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0);
    add_row(0, ACT_PUSH, 0, 9, 0, 0, 0, 0, 0);
    add_row(0, ACT_DELETE, 0, 0, 0, 0, 0, 0, 0);
    add_cfg(2);
    add_row(0, ACT_PUSH, 42, 10, 0, 0, 0, 0, 0);
    add_row(1, ACT_PUSH, 43, 11, 0, ST_FULL, 0, 0, 2);
    add_cfg(1);
    add_row(1, ACT_PUSH, 44, 12, 0, ST_FULL, 0, 0, 2);
    add_row(0, ACT_POP, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, ACT_PUSH, 45, 13, 0, ST_FULL, 0, 0, 1);
    add_row(1, ACT_DELETE, 77, 0, 0, ST_MISS, 0, 0, 1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_limit(CAP_W'(directed_rows[i].req.value));
      end else begin
        closing = (i + 1 == directed_rows.size()) || directed_rows[i + 1].is_cfg;
        issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want, closing);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet_tail = (p == NUM_PHASES - 1);
      write_limit(CAP_W'(cap_plan[p]));
      for (int k = 0; k < len_plan[p]; k++) begin
        r = make_request(push_plan[p]);
        issue(r, 1'b0, '0, k + 1 == len_plan[p]);
      end
    end

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
